// ===== src/rotary_encoder_button_interface_macros.svh =====
// ----------------------------------------------------------------------------
// Rotary encoder button interface - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_INTERFACE_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_INTERFACE_MACROS_SVH

// same-cycle implication
`define REBI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define REBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rebi_pkg.sv =====
// ----------------------------------------------------------------------------
// rebi_pkg
// Types, constants and helper functions of the rotary encoder button
// interface: event and direction codes, register indexes, ring indexing.
// ----------------------------------------------------------------------------
package rebi_pkg;

    // event ring geometry
    localparam int FIFO_DEPTH = 16;
    localparam int RING_AW    = $clog2(FIFO_DEPTH);
    localparam int CODE_W     = 2;
    localparam int LEVEL_W    = 4;
    localparam int CNT_W      = 16;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] CFG_STEPS_PER_DETENT = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_DEBOUNCE_MS      = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MODE_HOLD_MS     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_REBOOT_HOLD_MS   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_FACTORY_HOLD_MS  = 3'd4;

    // register reset values
    localparam logic [3:0]       RST_STEPS_PER_DETENT = 4'd4;
    localparam logic [CNT_W-1:0] RST_DEBOUNCE_MS      = 16'd50;
    localparam logic [CNT_W-1:0] RST_MODE_HOLD_MS     = 16'd1000;
    localparam logic [CNT_W-1:0] RST_REBOOT_HOLD_MS   = 16'd5000;
    localparam logic [CNT_W-1:0] RST_FACTORY_HOLD_MS  = 16'd10000;

    // event codes
    localparam logic [CODE_W-1:0] EV_RIGHT = 2'd0;
    localparam logic [CODE_W-1:0] EV_LEFT  = 2'd1;
    localparam logic [CODE_W-1:0] EV_SHORT = 2'd2;
    localparam logic [CODE_W-1:0] EV_MODE  = 2'd3;

    // turn direction codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;

    // quadrature step per {prev_phase, phase}: 2'b01 is +1, 2'b11 is -1
    localparam logic [1:0] STEP_TABLE [0:15] = '{
        2'b00, 2'b11, 2'b01, 2'b00,
        2'b01, 2'b00, 2'b00, 2'b11,
        2'b11, 2'b00, 2'b00, 2'b01,
        2'b00, 2'b01, 2'b11, 2'b00
    };

    // registered result word, popped code resolved at the output
    typedef struct packed {
        logic                popped_valid;
        logic                fwd_hit;
        logic [CODE_W-1:0]   fwd_code;
        logic [LEVEL_W-1:0]  fifo_level;
        logic                button_held;
        logic                held_long_enough;
        logic                reboot_warning;
        logic                factory_warning;
        logic                reboot_pulse;
        logic                factory_pulse;
        logic [1:0]          last_turn;
        logic [CNT_W-1:0]    hold_time;
    } t_result;

    // ring index advance with wrap
    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
        logic [RING_AW-1:0] nxt;
        if (idx == RING_AW'(FIFO_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

    // queued events between read and write index
    function automatic logic [LEVEL_W-1:0] ring_level(input logic [RING_AW-1:0] wr,
                                                      input logic [RING_AW-1:0] rd);
        logic [RING_AW:0] diff;
        diff = {1'b0, wr} - {1'b0, rd};
        if (wr < rd) begin
            diff = diff + (RING_AW+1)'(FIFO_DEPTH);
        end
        return LEVEL_W'(diff);
    endfunction

    // saturating counter step
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '1) begin
            r = v;
        end else begin
            r = v + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== src/rebi_ram.sv =====
// ----------------------------------------------------------------------------
// rebi_ram
// Simple dual-port synchronous RAM: one write port and one registered read
// port. Read during write returns the old data.
// ----------------------------------------------------------------------------
module rebi_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rotary_encoder_button_interface.sv =====
// Output: a word's result enters the output register on the edge that accepts it.
// Throughput: one word per cycle unless the output stalls; a word queuing both a turn and a
//   button event stalls the input for its second write, as the ring RAM has one write port.
// Reset: synchronous, active low; indexes, counters, flags and config return to their
//   initial values. Ring contents are not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
// rotary_encoder_button_interface
// Quadrature decoder with detent accumulator, debounced push button with hold
// classification, and an event ring held in a synchronous RAM.
// ----------------------------------------------------------------------------
`include "rotary_encoder_button_interface_macros.svh"

module rotary_encoder_button_interface (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [rebi_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [rebi_pkg::CFG_DW-1:0]         i_cfg_wdata,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_a_level,
    input  logic                                i_b_level,
    input  logic                                i_button_level,
    input  logic                                i_pop_request,
    input  logic                                i_clear_request,
    input  logic                                i_mode_mark,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_popped_valid,
    output logic [rebi_pkg::CODE_W-1:0]         o_popped_code,
    output logic [rebi_pkg::LEVEL_W-1:0]        o_fifo_level,
    output logic                                o_button_held,
    output logic                                o_held_long_enough,
    output logic                                o_reboot_warning,
    output logic                                o_factory_warning,
    output logic                                o_reboot_pulse,
    output logic                                o_factory_pulse,
    output logic [1:0]                          o_last_turn,
    output logic [rebi_pkg::CNT_W-1:0]          o_hold_time
);

    // configuration registers
    logic [3:0]                      r_cfg_steps;
    logic [rebi_pkg::CNT_W-1:0]      r_cfg_debounce;
    logic [rebi_pkg::CNT_W-1:0]      r_cfg_mode_hold;
    logic [rebi_pkg::CNT_W-1:0]      r_cfg_reboot_hold;
    logic [rebi_pkg::CNT_W-1:0]      r_cfg_factory_hold;

    // encoder state
    logic [1:0]                      r_prev_phase, n_prev_phase;
    logic signed [4:0]               r_accum, n_accum;
    logic [1:0]                      r_last_dir, n_last_dir;

    // ring indexes
    logic [rebi_pkg::RING_AW-1:0]    r_wr_idx, n_wr_idx;
    logic [rebi_pkg::RING_AW-1:0]    r_rd_idx, n_rd_idx;

    // button state
    logic                            r_prev_button;
    logic [rebi_pkg::CNT_W-1:0]      r_since, n_since;
    logic [rebi_pkg::CNT_W-1:0]      r_hold, n_hold;
    logic                            r_press, n_press;
    logic                            r_mode, n_mode;
    logic                            r_rwarn, n_rwarn;
    logic                            r_fwarn, n_fwarn;

    // deferred second ring write
    logic                            r_pend_valid;
    logic [rebi_pkg::RING_AW-1:0]    r_pend_addr;
    logic [rebi_pkg::CODE_W-1:0]     r_pend_code;

    // output register
    logic                            r_out_valid;
    rebi_pkg::t_result               r_out, n_out;

    // handshake
    logic                            in_accept;
    logic                            out_accept;

    // tick datapath
    logic [1:0]                      phase;
    logic [3:0]                      spd;
    logic signed [4:0]               spd_s;
    logic [1:0]                      step;
    logic signed [4:0]               acc_sum;
    logic                            want_a, want_b, push_a, push_b;
    logic [rebi_pkg::CODE_W-1:0]     code_a, code_b;
    logic [rebi_pkg::RING_AW-1:0]    wr_mid;
    logic                            held;
    logic                            edge_ok;
    logic                            rpulse, fpulse;
    logic                            pop_ok;

    // ring RAM port
    logic                            ram_we;
    logic [rebi_pkg::RING_AW-1:0]    ram_waddr;
    logic [rebi_pkg::CODE_W-1:0]     ram_wdata;
    logic [rebi_pkg::CODE_W-1:0]     ram_rdata;

    // hold the input while the second ring write drains or the output is full
    assign o_stall    = r_pend_valid || (r_out_valid && i_stall);
    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_out_valid && !i_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_steps        <= rebi_pkg::RST_STEPS_PER_DETENT;
            r_cfg_debounce     <= rebi_pkg::RST_DEBOUNCE_MS;
            r_cfg_mode_hold    <= rebi_pkg::RST_MODE_HOLD_MS;
            r_cfg_reboot_hold  <= rebi_pkg::RST_REBOOT_HOLD_MS;
            r_cfg_factory_hold <= rebi_pkg::RST_FACTORY_HOLD_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rebi_pkg::CFG_STEPS_PER_DETENT: r_cfg_steps        <= i_cfg_wdata[3:0];
                rebi_pkg::CFG_DEBOUNCE_MS:      r_cfg_debounce     <= i_cfg_wdata;
                rebi_pkg::CFG_MODE_HOLD_MS:     r_cfg_mode_hold    <= i_cfg_wdata;
                rebi_pkg::CFG_REBOOT_HOLD_MS:   r_cfg_reboot_hold  <= i_cfg_wdata;
                rebi_pkg::CFG_FACTORY_HOLD_MS:  r_cfg_factory_hold <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // one tick of encoder, button and queue update
    always_comb begin
        phase  = {i_a_level, i_b_level};
        spd    = (r_cfg_steps == 4'd0) ? 4'd1 : r_cfg_steps;
        spd_s  = signed'({1'b0, spd});
        step   = rebi_pkg::STEP_TABLE[{r_prev_phase, phase}];
        acc_sum = r_accum + signed'({{3{step[1]}}, step});

        n_prev_phase = r_prev_phase;
        n_accum      = r_accum;
        n_last_dir   = r_last_dir;
        want_a       = 1'b0;
        code_a       = rebi_pkg::EV_RIGHT;

        // quadrature step and detent
        if (phase != r_prev_phase) begin
            n_prev_phase = phase;
            n_accum      = acc_sum;
            if (acc_sum >= spd_s) begin
                want_a     = 1'b1;
                code_a     = rebi_pkg::EV_RIGHT;
                n_last_dir = rebi_pkg::DIR_RIGHT;
                n_accum    = '0;
            end else if (acc_sum <= -spd_s) begin
                want_a     = 1'b1;
                code_a     = rebi_pkg::EV_LEFT;
                n_last_dir = rebi_pkg::DIR_LEFT;
                n_accum    = '0;
            end
        end

        push_a = want_a && (rebi_pkg::ring_next(r_wr_idx) != r_rd_idx);
        wr_mid = push_a ? rebi_pkg::ring_next(r_wr_idx) : r_wr_idx;

        // time counters
        n_mode  = r_mode || i_mode_mark;
        n_since = rebi_pkg::sat_inc(r_since);
        n_hold  = r_press ? rebi_pkg::sat_inc(r_hold) : r_hold;
        n_press = r_press;
        n_rwarn = r_rwarn;
        n_fwarn = r_fwarn;
        held    = !i_button_level && r_press;
        rpulse  = 1'b0;
        fpulse  = 1'b0;
        want_b  = 1'b0;
        code_b  = rebi_pkg::EV_SHORT;

        // hold warnings, factory first
        if (held) begin
            if (n_mode) begin
                n_rwarn = 1'b0;
                n_fwarn = 1'b0;
            end else if (n_hold >= r_cfg_factory_hold && !r_fwarn) begin
                n_fwarn = 1'b1;
            end else if (n_hold >= r_cfg_reboot_hold && !r_rwarn) begin
                n_rwarn = 1'b1;
            end
        end

        // debounced press and release
        edge_ok = (i_button_level != r_prev_button) && (n_since > r_cfg_debounce);
        if (edge_ok) begin
            if (!i_button_level) begin
                n_press = 1'b1;
                held    = 1'b1;
                n_hold  = '0;
                n_mode  = 1'b0;
                n_rwarn = 1'b0;
                n_fwarn = 1'b0;
                n_since = '0;
            end else if (r_press) begin
                if (n_mode) begin
                    want_b = 1'b1;
                    code_b = rebi_pkg::EV_MODE;
                end else if (n_hold >= r_cfg_factory_hold) begin
                    fpulse = 1'b1;
                end else if (n_hold >= r_cfg_reboot_hold) begin
                    rpulse = 1'b1;
                end else begin
                    want_b = 1'b1;
                    code_b = rebi_pkg::EV_SHORT;
                end
                n_press = 1'b0;
                held    = 1'b0;
                n_mode  = 1'b0;
                n_rwarn = 1'b0;
                n_fwarn = 1'b0;
                n_since = '0;
            end
        end

        push_b   = want_b && (rebi_pkg::ring_next(wr_mid) != r_rd_idx);
        n_wr_idx = push_b ? rebi_pkg::ring_next(wr_mid) : wr_mid;

        // pop then clear
        pop_ok   = i_pop_request && (r_rd_idx != n_wr_idx);
        n_rd_idx = pop_ok ? rebi_pkg::ring_next(r_rd_idx) : r_rd_idx;
        if (i_clear_request) begin
            n_rd_idx = n_wr_idx;
        end

        // result word, with forwarding of an entry written in this tick
        n_out.popped_valid     = pop_ok;
        n_out.fwd_hit          = (push_a && (r_wr_idx == r_rd_idx))
                              || (push_b && (wr_mid == r_rd_idx));
        n_out.fwd_code         = (push_a && (r_wr_idx == r_rd_idx)) ? code_a : code_b;
        n_out.fifo_level       = rebi_pkg::ring_level(n_wr_idx, n_rd_idx);
        n_out.button_held      = held;
        n_out.held_long_enough = held && (n_hold >= r_cfg_mode_hold);
        n_out.reboot_warning   = n_rwarn;
        n_out.factory_warning  = n_fwarn;
        n_out.reboot_pulse     = rpulse;
        n_out.factory_pulse    = fpulse;
        n_out.last_turn        = n_last_dir;
        n_out.hold_time        = held ? n_hold : '0;
    end

    // ring write port: deferred write first, else this tick's first push
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pend_addr;
        ram_wdata = r_pend_code;
        if (r_pend_valid) begin
            ram_we = 1'b1;
        end else if (in_accept && push_a) begin
            ram_we    = 1'b1;
            ram_waddr = r_wr_idx;
            ram_wdata = code_a;
        end else if (in_accept && push_b) begin
            ram_we    = 1'b1;
            ram_waddr = wr_mid;
            ram_wdata = code_b;
        end
    end

    // event ring storage
    rebi_ram #(
        .WIDTH (rebi_pkg::CODE_W),
        .DEPTH (rebi_pkg::FIFO_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // state update on accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase  <= 2'b11;
            r_accum       <= '0;
            r_last_dir    <= rebi_pkg::DIR_NONE;
            r_wr_idx      <= '0;
            r_rd_idx      <= '0;
            r_prev_button <= 1'b1;
            r_since       <= '1;
            r_hold        <= '0;
            r_press       <= 1'b0;
            r_mode        <= 1'b0;
            r_rwarn       <= 1'b0;
            r_fwarn       <= 1'b0;
        end else if (in_accept) begin
            r_prev_phase  <= n_prev_phase;
            r_accum       <= n_accum;
            r_last_dir    <= n_last_dir;
            r_wr_idx      <= n_wr_idx;
            r_rd_idx      <= n_rd_idx;
            r_prev_button <= i_button_level;
            r_since       <= n_since;
            r_hold        <= n_hold;
            r_press       <= n_press;
            r_mode        <= n_mode;
            r_rwarn       <= n_rwarn;
            r_fwarn       <= n_fwarn;
        end
    end

    // second push of a tick is written from the pending register in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (in_accept && push_a && push_b) begin
            r_pend_valid <= 1'b1;
        end else begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && push_a && push_b) begin
            r_pend_addr <= wr_mid;
            r_pend_code <= code_b;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    // output word
    assign o_valid            = r_out_valid;
    assign o_popped_valid     = r_out.popped_valid;
    assign o_popped_code      = !r_out.popped_valid ? rebi_pkg::EV_RIGHT
                              : (r_out.fwd_hit ? r_out.fwd_code : ram_rdata);
    assign o_fifo_level       = r_out.fifo_level;
    assign o_button_held      = r_out.button_held;
    assign o_held_long_enough = r_out.held_long_enough;
    assign o_reboot_warning   = r_out.reboot_warning;
    assign o_factory_warning  = r_out.factory_warning;
    assign o_reboot_pulse     = r_out.reboot_pulse;
    assign o_factory_pulse    = r_out.factory_pulse;
    assign o_last_turn        = r_out.last_turn;
    assign o_hold_time        = r_out.hold_time;

    // checks
    `REBI_ASSERT_NOW(a_pend_blocks_input, i_clk, i_rst_n, r_pend_valid, o_stall, "deferred ring write did not hold the input")
    `REBI_ASSERT_NEXT(a_pend_one_cycle, i_clk, i_rst_n, r_pend_valid, !r_pend_valid, "deferred ring write lasted more than one cycle")
    `REBI_ASSERT_NOW(a_pulses_exclusive, i_clk, i_rst_n, o_valid, !(o_reboot_pulse && o_factory_pulse), "reboot and factory pulse together")
    `REBI_ASSERT_NOW(a_hold_time_held, i_clk, i_rst_n, o_valid && (o_hold_time != '0), o_button_held, "hold time shown without a held button")
    `REBI_ASSERT_NOW(a_long_needs_held, i_clk, i_rst_n, o_valid && o_held_long_enough, o_button_held, "long hold flagged without a held button")

endmodule

// ===== tb/rebi_tick_checker.sv =====
// ----------------------------------------------------------------------------
// rebi_tick_checker
// Watches the configuration port and both word channels of the rotary
// encoder button interface. It keeps its own copy of the encoder, debounce,
// hold and event ring state, predicts the result of every accepted input
// word and compares each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module rebi_tick_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration port
    input  logic                             i_cfg_we,
    input  logic [rebi_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [rebi_pkg::CFG_DW-1:0]      i_cfg_wdata,
    // input channel
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_a_level,
    input  logic                             i_b_level,
    input  logic                             i_button_level,
    input  logic                             i_pop_request,
    input  logic                             i_clear_request,
    input  logic                             i_mode_mark,
    // output channel
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_popped_valid,
    input  logic [rebi_pkg::CODE_W-1:0]      i_popped_code,
    input  logic [rebi_pkg::LEVEL_W-1:0]     i_fifo_level,
    input  logic                             i_button_held,
    input  logic                             i_held_long_enough,
    input  logic                             i_reboot_warning,
    input  logic                             i_factory_warning,
    input  logic                             i_reboot_pulse,
    input  logic                             i_factory_pulse,
    input  logic [1:0]                       i_last_turn,
    input  logic [rebi_pkg::CNT_W-1:0]       i_hold_time,
    // status towards the stimulus side
    output int                               o_pending,
    output int                               o_fail_count
);
    import rebi_pkg::*;

    typedef struct packed {
        logic a;
        logic b;
        logic button;
        logic pop;
        logic clr;
        logic mark;
    } t_tick;

    typedef struct packed {
        logic               popped_valid;
        logic [CODE_W-1:0]  popped_code;
        logic [LEVEL_W-1:0] fifo_level;
        logic               button_held;
        logic               held_long_enough;
        logic               reboot_warning;
        logic               factory_warning;
        logic               reboot_pulse;
        logic               factory_pulse;
        logic [1:0]         last_turn;
        logic [CNT_W-1:0]   hold_time;
    } t_outcome;

    // shadow configuration
    logic [3:0]       steps_cfg;
    logic [CNT_W-1:0] debounce_cfg;
    logic [CNT_W-1:0] mode_cfg;
    logic [CNT_W-1:0] reboot_cfg;
    logic [CNT_W-1:0] factory_cfg;

    // shadow encoder, button and ring state
    logic [1:0]        last_phase;
    int                detent_sum;
    logic [1:0]        turn_dir;
    logic [CODE_W-1:0] events [FIFO_DEPTH];
    int                wr_ptr;
    int                rd_ptr;
    logic              last_button;
    logic [CNT_W-1:0]  edge_age;
    logic [CNT_W-1:0]  press_age;
    logic              pressed;
    logic              holding;
    logic              mode_seen;
    logic              rb_alert;
    logic              fr_alert;

    t_outcome due_outcomes [$];
    int       fail_total;
    int       words_seen;

    assign o_fail_count = fail_total;

    // position along the forward rotation cycle 00, 10, 11, 01
    function automatic int cycle_pos(input logic [1:0] ph);
        case (ph)
            2'b00:   return 0;
            2'b10:   return 1;
            2'b11:   return 2;
            default: return 3;
        endcase
    endfunction

    // one forward position is a step right, one backward a step left,
    // a jump across two phases counts nothing
    function automatic int quad_step(input logic [1:0] from, input logic [1:0] to);
        int d;
        d = (cycle_pos(to) - cycle_pos(from) + 4) % 4;
        return (d == 1) ? 1 : (d == 3) ? -1 : 0;
    endfunction

    function automatic int ring_inc(input int idx);
        return (idx + 1) % FIFO_DEPTH;
    endfunction

    // push into the ring, dropped when it holds depth minus one events
    function automatic void queue_event(input logic [CODE_W-1:0] code);
        if (ring_inc(wr_ptr) != rd_ptr) begin
            events[wr_ptr] = code;
            wr_ptr = ring_inc(wr_ptr);
        end
    endfunction

    function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_hold_state();
        mode_seen = 1'b0;
        rb_alert  = 1'b0;
        fr_alert  = 1'b0;
    endfunction

    function automatic void reset_shadow();
        steps_cfg    = RST_STEPS_PER_DETENT;
        debounce_cfg = RST_DEBOUNCE_MS;
        mode_cfg     = RST_MODE_HOLD_MS;
        reboot_cfg   = RST_REBOOT_HOLD_MS;
        factory_cfg  = RST_FACTORY_HOLD_MS;
        last_phase   = 2'b11;
        detent_sum   = 0;
        turn_dir     = DIR_NONE;
        wr_ptr       = 0;
        rd_ptr       = 0;
        last_button  = 1'b1;
        edge_age     = '1;
        press_age    = '0;
        pressed      = 1'b0;
        holding      = 1'b0;
        clear_hold_state();
    endfunction

    // full effect of one tick word on the shadow state
    function automatic t_outcome encoder_tick_outcome(input t_tick w);
        t_outcome   r;
        logic [1:0] ph;
        int         detent;
        logic       rb_req;
        logic       fr_req;
        r      = '0;
        rb_req = 1'b0;
        fr_req = 1'b0;
        ph     = {w.a, w.b};
        detent = (steps_cfg == 4'd0) ? 1 : int'(steps_cfg);

        // quadrature and detent
        if (ph != last_phase) begin
            detent_sum += quad_step(last_phase, ph);
            last_phase = ph;
            if (detent_sum >= detent) begin
                queue_event(EV_RIGHT);
                turn_dir   = DIR_RIGHT;
                detent_sum = 0;
            end else if (detent_sum <= -detent) begin
                queue_event(EV_LEFT);
                turn_dir   = DIR_LEFT;
                detent_sum = 0;
            end
        end

        if (w.mark) mode_seen = 1'b1;

        edge_age = sat_up(edge_age);
        if (pressed) press_age = sat_up(press_age);

        // warnings while held, factory first
        holding = !w.button && pressed;
        if (holding) begin
            if (mode_seen) begin
                rb_alert = 1'b0;
                fr_alert = 1'b0;
            end else if (press_age >= factory_cfg && !fr_alert) begin
                fr_alert = 1'b1;
            end else if (press_age >= reboot_cfg && !rb_alert) begin
                rb_alert = 1'b1;
            end
        end

        // debounced press and release
        if (w.button != last_button && edge_age > debounce_cfg) begin
            if (!w.button) begin
                pressed   = 1'b1;
                holding   = 1'b1;
                press_age = '0;
                clear_hold_state();
                edge_age  = '0;
            end else if (pressed) begin
                if (mode_seen) queue_event(EV_MODE);
                else if (press_age >= factory_cfg) fr_req = 1'b1;
                else if (press_age >= reboot_cfg) rb_req = 1'b1;
                else queue_event(EV_SHORT);
                pressed  = 1'b0;
                holding  = 1'b0;
                clear_hold_state();
                edge_age = '0;
            end
        end
        last_button = w.button;

        // pop, then clear
        if (w.pop && rd_ptr != wr_ptr) begin
            r.popped_valid = 1'b1;
            r.popped_code  = events[rd_ptr];
            rd_ptr         = ring_inc(rd_ptr);
        end
        if (w.clr) rd_ptr = wr_ptr;

        r.fifo_level       = LEVEL_W'((wr_ptr - rd_ptr + FIFO_DEPTH) % FIFO_DEPTH);
        r.button_held      = holding;
        r.held_long_enough = holding && (press_age >= mode_cfg);
        r.reboot_warning   = rb_alert;
        r.factory_warning  = fr_alert;
        r.reboot_pulse     = rb_req;
        r.factory_pulse    = fr_req;
        r.last_turn        = turn_dir;
        r.hold_time        = holding ? press_age : '0;
        return r;
    endfunction

    function automatic void note_failure(input string what, input int unsigned want,
                                         input int unsigned got);
        fail_total++;
        if (fail_total <= 10)
            $display("result word %0d: %s expected %0d, got %0d", words_seen, what, want, got);
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) note_failure(what, want, got);
    endfunction

    initial begin
        fail_total = 0;
        words_seen = 0;
        reset_shadow();
    end

    // compare results, follow register writes, predict accepted words
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            reset_shadow();
            due_outcomes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_popped_valid, i_popped_code, i_fifo_level, i_button_held,
                        i_held_long_enough, i_reboot_warning, i_factory_warning,
                        i_reboot_pulse, i_factory_pulse, i_last_turn, i_hold_time};
                if (due_outcomes.size() == 0) begin
                    note_failure("unexpected word, words waiting", 0, 1);
                end else begin
                    want = due_outcomes.pop_front();
                    check_field("popped_valid", want.popped_valid, got.popped_valid);
                    check_field("popped_code", want.popped_code, got.popped_code);
                    check_field("fifo_level", want.fifo_level, got.fifo_level);
                    check_field("button_held", want.button_held, got.button_held);
                    check_field("held_long_enough", want.held_long_enough,
                                got.held_long_enough);
                    check_field("reboot_warning", want.reboot_warning, got.reboot_warning);
                    check_field("factory_warning", want.factory_warning,
                                got.factory_warning);
                    check_field("reboot_pulse", want.reboot_pulse, got.reboot_pulse);
                    check_field("factory_pulse", want.factory_pulse, got.factory_pulse);
                    check_field("last_turn", want.last_turn, got.last_turn);
                    check_field("hold_time", want.hold_time, got.hold_time);
                end
                words_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_STEPS_PER_DETENT: steps_cfg    = i_cfg_wdata[3:0];
                    CFG_DEBOUNCE_MS:      debounce_cfg = i_cfg_wdata;
                    CFG_MODE_HOLD_MS:     mode_cfg     = i_cfg_wdata;
                    CFG_REBOOT_HOLD_MS:   reboot_cfg   = i_cfg_wdata;
                    CFG_FACTORY_HOLD_MS:  factory_cfg  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                due_outcomes.push_back(encoder_tick_outcome('{i_a_level, i_b_level,
                    i_button_level, i_pop_request, i_clear_request, i_mode_mark}));
            end
        end
        o_pending <= due_outcomes.size();
    end

endmodule

// ===== tb/tb_rotary_encoder_button_interface.sv =====
// ----------------------------------------------------------------------------
// tb_rotary_encoder_button_interface
// Drives tick words into the rotary encoder button interface: a directed run
// over turns, jumps, presses, hold warnings, release classes and queue access,
// then random rotation and press sequences under several register settings
// and flow control patterns.
// Checking is done by rebi_tick_checker.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_button_interface;
    import rebi_pkg::*;

    localparam int LIMIT       = 400000;
    localparam int PHASE_WORDS = 128;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_we        = 1'b0;
    logic [CFG_AW-1:0]   i_cfg_addr      = '0;
    logic [CFG_DW-1:0]   i_cfg_wdata     = '0;
    logic                i_valid         = 1'b0;
    logic                i_stall         = 1'b0;
    logic                i_a_level       = 1'b1;
    logic                i_b_level       = 1'b1;
    logic                i_button_level  = 1'b1;
    logic                i_pop_request   = 1'b0;
    logic                i_clear_request = 1'b0;
    logic                i_mode_mark     = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_popped_valid;
    logic [CODE_W-1:0]   o_popped_code;
    logic [LEVEL_W-1:0]  o_fifo_level;
    logic                o_button_held;
    logic                o_held_long_enough;
    logic                o_reboot_warning;
    logic                o_factory_warning;
    logic                o_reboot_pulse;
    logic                o_factory_pulse;
    logic [1:0]          o_last_turn;
    logic [CNT_W-1:0]    o_hold_time;

    int pending;
    int fail_count;
    int cycle_count = 0;

    // flow control and stimulus shaping
    int gap_pct   = 0;
    int stall_pct = 0;
    int pop_pct   = 40;
    int cur_deb   = 0;
    int cur_mode  = 0;
    int cur_rb    = 0;
    int cur_fr    = 0;

    // random sequence state
    logic [1:0] enc_phase = 2'b11;
    logic       enc_fwd   = 1'b1;
    logic       btn_state = 1'b1;
    int         btn_left  = 0;

    always #10 i_clk = ~i_clk;

    rotary_encoder_button_interface DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_a_level          (i_a_level),
        .i_b_level          (i_b_level),
        .i_button_level     (i_button_level),
        .i_pop_request      (i_pop_request),
        .i_clear_request    (i_clear_request),
        .i_mode_mark        (i_mode_mark),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_popped_valid     (o_popped_valid),
        .o_popped_code      (o_popped_code),
        .o_fifo_level       (o_fifo_level),
        .o_button_held      (o_button_held),
        .o_held_long_enough (o_held_long_enough),
        .o_reboot_warning   (o_reboot_warning),
        .o_factory_warning  (o_factory_warning),
        .o_reboot_pulse     (o_reboot_pulse),
        .o_factory_pulse    (o_factory_pulse),
        .o_last_turn        (o_last_turn),
        .o_hold_time        (o_hold_time)
    );

    rebi_tick_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_a_level          (i_a_level),
        .i_b_level          (i_b_level),
        .i_button_level     (i_button_level),
        .i_pop_request      (i_pop_request),
        .i_clear_request    (i_clear_request),
        .i_mode_mark        (i_mode_mark),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_popped_valid     (o_popped_valid),
        .i_popped_code      (o_popped_code),
        .i_fifo_level       (o_fifo_level),
        .i_button_held      (o_button_held),
        .i_held_long_enough (o_held_long_enough),
        .i_reboot_warning   (o_reboot_warning),
        .i_factory_warning  (o_factory_warning),
        .i_reboot_pulse     (o_reboot_pulse),
        .i_factory_pulse    (o_factory_pulse),
        .i_last_turn        (o_last_turn),
        .i_hold_time        (o_hold_time),
        .o_pending          (pending),
        .o_fail_count       (fail_count)
    );

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("tb_rotary_encoder_button_interface failed");
            $finish;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // one tick word, with random sender gaps ahead of it
    task automatic send_word(input logic a, input logic b, input logic btn,
                             input logic pop, input logic clr, input logic mark);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_a_level       <= a;
        i_b_level       <= b;
        i_button_level  <= btn;
        i_pop_request   <= pop;
        i_clear_request <= clr;
        i_mode_mark     <= mark;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // stop sending and wait until every result word has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_AW-1:0] addr, input int unsigned data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= CFG_DW'(data);
        @(posedge i_clk);
    endtask

    task automatic set_config(input int spd, input int deb, input int mode,
                              input int rb, input int fr);
        put_reg(CFG_STEPS_PER_DETENT, spd);
        put_reg(CFG_DEBOUNCE_MS, deb);
        put_reg(CFG_MODE_HOLD_MS, mode);
        put_reg(CFG_REBOOT_HOLD_MS, rb);
        put_reg(CFG_FACTORY_HOLD_MS, fr);
        i_cfg_we <= 1'b0;
        cur_deb  = deb;
        cur_mode = mode;
        cur_rb   = rb;
        cur_fr   = fr;
    endtask

    // register setting, queue drain rate and flow control of one random phase
    task automatic apply_phase(input int p);
        case (p)
            0: begin set_config(1, 0, 0, 0, 0);                     pop_pct = 50; end
            1: begin set_config(2, 2, 3, 6, 10);                    pop_pct = 30; end
            2: begin set_config(4, 3, 5, 9, 14);                    pop_pct = 10; end
            3: begin set_config(8, 1, 2, 12, 6);                    pop_pct = 40; end
            4: begin set_config(15, 65535, 65535, 65535, 65535);    pop_pct = 40; end
            5: begin set_config(0, 5, 4, 8, 12);                    pop_pct = 20; end
            6: begin set_config(3, 0, 1, 3, 5);                     pop_pct = 5;  end
            7: begin set_config(4, 10, 8, 20, 30);                  pop_pct = 60; end
            default: begin set_config(1, 50, 1000, 5000, 10000);    pop_pct = 50; end
        endcase
        case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 47; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 47; end
            default: begin gap_pct = 19; stall_pct = 19; end
        endcase
    endtask

    // press length that lands near one of the hold thresholds
    function automatic int pick_hold();
        int target;
        case ($urandom_range(0, 2))
            0:       target = cur_mode;
            1:       target = cur_rb;
            default: target = cur_fr;
        endcase
        if (target > 36) target = $urandom_range(1, 36);
        target = target + $urandom_range(0, 4) - 1;
        return (target < 1) ? 1 : target;
    endfunction

    // rotation with direction changes and rare jumps, presses, bounce, queue use
    task automatic random_word();
        int   r;
        logic lvl;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            enc_phase = 2'($urandom_range(0, 3));
        end else if (r < 45) begin
            if ($urandom_range(0, 99) < 10) enc_fwd = ~enc_fwd;
            case (enc_phase)
                2'b00:   enc_phase = enc_fwd ? 2'b10 : 2'b01;
                2'b10:   enc_phase = enc_fwd ? 2'b11 : 2'b00;
                2'b11:   enc_phase = enc_fwd ? 2'b01 : 2'b10;
                default: enc_phase = enc_fwd ? 2'b00 : 2'b11;
            endcase
        end
        if (btn_left <= 0) begin
            btn_state = ~btn_state;
            btn_left  = btn_state ? $urandom_range(1, (cur_deb > 30) ? 30 : cur_deb + 3)
                                  : pick_hold();
        end
        btn_left--;
        lvl = btn_state;
        if ($urandom_range(0, 99) < 4) lvl = ~lvl;
        send_word(enc_phase[1], enc_phase[0], lvl,
                  $urandom_range(0, 99) < pop_pct,
                  $urandom_range(0, 99) < 2,
                  $urandom_range(0, 99) < 4);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one step per detent, immediate debounce, short thresholds
        set_config(0, 0, 2, 4, 6);
        send_word(1, 1, 1, 1, 0, 0);              // pop on empty queue
        send_word(0, 1, 1, 0, 0, 0);              // right step
        send_word(0, 0, 1, 0, 0, 0);              // right step
        send_word(1, 1, 1, 0, 0, 0);              // jump across two phases
        send_word(1, 0, 1, 0, 0, 0);              // left step
        send_word(1, 0, 0, 0, 0, 1);              // press clears a mark of the same tick
        repeat (7) send_word(1, 0, 0, 0, 0, 0);   // hold through all warnings
        send_word(1, 0, 1, 0, 0, 0);              // factory request on release
        send_word(1, 0, 0, 0, 0, 0);
        send_word(1, 0, 1, 0, 0, 0);              // short press
        send_word(1, 0, 0, 0, 0, 0);
        send_word(1, 0, 0, 0, 0, 1);              // mode change during hold
        send_word(1, 0, 1, 0, 0, 0);              // mode confirm
        send_word(1, 0, 1, 1, 0, 0);
        send_word(1, 0, 1, 1, 1, 0);              // pop and clear together
        send_word(1, 0, 1, 1, 0, 0);
        enc_phase = 2'b10;

        // random phases
        for (int p = 0; p < 9; p++) begin
            drain();
            apply_phase(p);
            repeat (PHASE_WORDS) random_word();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_rotary_encoder_button_interface passed");
        end else begin
            $display("tb_rotary_encoder_button_interface failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rebi_pkg.sv
src/rebi_ram.sv
src/rotary_encoder_button_interface.sv
tb/rebi_tick_checker.sv
tb/tb_rotary_encoder_button_interface.sv
